>>> src/shape_fill_rasterizer_macros.svh
// Assertion macros for the shape fill rasterizer.
// Each macro expects clk and rst in scope.
`ifndef SHAPE_FILL_RASTERIZER_MACROS_SVH
`define SHAPE_FILL_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shape_fill_rasterizer: same-cycle check failed");
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shape_fill_rasterizer: next-cycle check failed");
`else
`define SFR_ASSERT_IMPLIES(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/shf_pkg.sv
package shf_pkg;

  localparam int COORD_W  = 10;  // holds any column or row below 1024
  localparam int CLIP_W   = 12;  // signed width for clipping compares
  localparam int CENTER_W = 14;
  localparam int RADIUS_W = 13;
  localparam int PAINT_W  = 32;
  localparam int DIM_W    = 7;
  localparam int INDEX_W  = 2;

  localparam logic [DIM_W-1:0] CANVAS_RESET = 7'd64;

  localparam logic [INDEX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    KIND_FILL    = 2'd0,
    KIND_RECT    = 2'd1,
    KIND_ELLIPSE = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  // One classified command. For a read, x_lo/y_lo hold the pixel and skip
  // marks it outside the canvas; otherwise skip marks an empty drawing.
  typedef struct packed {
    kind_t                      kind;
    logic                       skip;
    logic [COORD_W-1:0]         x_lo;
    logic [COORD_W-1:0]         x_hi;
    logic [COORD_W-1:0]         y_lo;
    logic [COORD_W-1:0]         y_hi;
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [RADIUS_W-1:0]        rx;
    logic [RADIUS_W-1:0]        ry;
    logic [PAINT_W-1:0]         paint;
  } cmd_t;

endpackage

>>> src/shape_fill_rasterizer.sv
// Shape fill rasterizer: fills and reads a MAX_WIDTH x MAX_HEIGHT store of
// 32-bit BGRA pixels.
// Input channel (in_valid/in_ready) carries one command per transfer: fill
// canvas, fill clipped rectangle, fill ellipse, or read one pixel. Output
// channel (out_valid/out_ready) returns exactly one result per command, in
// order: the pixel read and its out-of-range flag, zeros for drawing commands.
// cfg_we/cfg_index/cfg_data set canvas width (index 0) and height (index 1).
// A command is classified and registered, then waits in a two-entry queue
// while the drawing engine works through the previous one.
// A fill, rectangle or ellipse writes through the one-pixel-per-cycle write
// port of the frame store; an ellipse scans the whole canvas. The engine
// takes the next command only after the result of the previous one is loaded.
// After reset all MAX_WIDTH*MAX_HEIGHT words (4096 by default) of the store
// are cleared one word per cycle; in_ready stays low during that pass.
// While out_ready is low the finished result is held; up to four more
// commands are taken in before in_ready drops.
`include "shape_fill_rasterizer_macros.svh"

module shape_fill_rasterizer #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [shf_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [shf_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic signed [10:0]                  corner_x0,
  input  logic signed [10:0]                  corner_y0,
  input  logic signed [10:0]                  corner_x1,
  input  logic signed [10:0]                  corner_y1,
  input  logic signed [shf_pkg::CENTER_W-1:0] center_x,
  input  logic signed [shf_pkg::CENTER_W-1:0] center_y,
  input  logic [shf_pkg::RADIUS_W-1:0]        radius_x,
  input  logic [shf_pkg::RADIUS_W-1:0]        radius_y,
  input  logic [shf_pkg::PAINT_W-1:0]         paint,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [shf_pkg::PAINT_W-1:0]         pixel_value,
  output logic                                out_of_range
);

  logic          clearing;
  logic          front_valid, front_ready;
  shf_pkg::cmd_t front_cmd;
  logic          cmd_valid, cmd_ready;
  shf_pkg::cmd_t cmd;

  shf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .corner_x0(corner_x0),
    .corner_y0(corner_y0),
    .corner_x1(corner_x1),
    .corner_y1(corner_y1),
    .center_x (center_x),
    .center_y (center_y),
    .radius_x (radius_x),
    .radius_y (radius_y),
    .paint    (paint),
    .clearing (clearing),
    .cmd_valid(front_valid),
    .cmd_ready(front_ready),
    .cmd      (front_cmd)
  );

  shf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(cmd_valid),
    .out_ready(cmd_ready),
    .out_cmd  (cmd)
  );

  shf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .out_of_range(out_of_range)
  );

  `SFR_ASSERT_IMPLIES(a_clear_blocks_input, clearing, !in_ready)
  `SFR_ASSERT_IMPLIES(a_clear_no_result, clearing, !out_valid)
  `SFR_ASSERT_IMPLIES(a_oor_reads_zero, out_valid && out_of_range, pixel_value == '0)
  `SFR_ASSERT_NEXT(a_engine_busy_after_take, cmd_valid && cmd_ready, !cmd_ready)

endmodule

>>> src/shf_front.sv
module shf_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [shf_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [shf_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic signed [10:0]                  corner_x0,
  input  logic signed [10:0]                  corner_y0,
  input  logic signed [10:0]                  corner_x1,
  input  logic signed [10:0]                  corner_y1,
  input  logic signed [shf_pkg::CENTER_W-1:0] center_x,
  input  logic signed [shf_pkg::CENTER_W-1:0] center_y,
  input  logic [shf_pkg::RADIUS_W-1:0]        radius_x,
  input  logic [shf_pkg::RADIUS_W-1:0]        radius_y,
  input  logic [shf_pkg::PAINT_W-1:0]         paint,
  input  logic                                clearing,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output shf_pkg::cmd_t                       cmd
);

  localparam int CW   = shf_pkg::CLIP_W;
  localparam int KW   = shf_pkg::COORD_W;
  localparam int RW   = shf_pkg::RADIUS_W;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  logic [shf_pkg::DIM_W-1:0] canvas_width;
  logic [shf_pkg::DIM_W-1:0] canvas_height;
  logic                      st_valid;
  shf_pkg::cmd_t             cmd_next;
  logic                      accept;

  logic signed [CW-1:0] w_lim, h_lim;
  logic signed [CW-1:0] x0_s, y0_s, x1_s, y1_s;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !clearing && (!st_valid || cmd_ready);
  assign cmd_valid = st_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= shf_pkg::CANVAS_RESET;
      canvas_height <= shf_pkg::CANVAS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        shf_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        shf_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Largest usable column and row: zero acts as one, oversize as the maximum
  always_comb begin
    if (canvas_width == '0) begin
      w_lim = '0;
    end else if (32'(canvas_width) > MAX_WIDTH) begin
      w_lim = CW'(MAX_WIDTH - 1);
    end else begin
      w_lim = CW'(canvas_width) - CW'(1);
    end
    if (canvas_height == '0) begin
      h_lim = '0;
    end else if (32'(canvas_height) > MAX_HEIGHT) begin
      h_lim = CW'(MAX_HEIGHT - 1);
    end else begin
      h_lim = CW'(canvas_height) - CW'(1);
    end
  end

  always_comb begin
    x0_s = CW'(corner_x0);
    y0_s = CW'(corner_y0);
    x1_s = CW'(corner_x1);
    y1_s = CW'(corner_y1);
    lo_x = '0;
    lo_y = '0;
    hi_x = w_lim;
    hi_y = h_lim;
    cmd_next       = '0;
    cmd_next.kind  = shf_pkg::kind_t'(kind);
    cmd_next.cx    = center_x;
    cmd_next.cy    = center_y;
    cmd_next.rx    = radius_x;
    cmd_next.ry    = radius_y;
    cmd_next.paint = paint;
    case (shf_pkg::kind_t'(kind))
      shf_pkg::KIND_RECT: begin
        lo_x = (x0_s < 0) ? '0 : x0_s;
        lo_y = (y0_s < 0) ? '0 : y0_s;
        hi_x = (x1_s > w_lim) ? w_lim : x1_s;
        hi_y = (y1_s > h_lim) ? h_lim : y1_s;
        cmd_next.skip = (lo_x > hi_x) || (lo_y > hi_y);
      end
      shf_pkg::KIND_ELLIPSE: begin
        cmd_next.skip = (radius_x < RW'(HALF)) || (radius_y < RW'(HALF));
      end
      shf_pkg::KIND_READ: begin
        lo_x = x0_s;
        lo_y = y0_s;
        cmd_next.skip = (x0_s < 0) || (y0_s < 0) || (x0_s > w_lim) || (y0_s > h_lim);
      end
      default: ;
    endcase
    cmd_next.x_lo = lo_x[KW-1:0];
    cmd_next.x_hi = hi_x[KW-1:0];
    cmd_next.y_lo = lo_y[KW-1:0];
    cmd_next.y_hi = hi_y[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (cmd_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

>>> src/shf_queue.sv
module shf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  shf_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output shf_pkg::cmd_t out_cmd
);

  localparam int DEPTH = 2;

  shf_pkg::cmd_t slots [DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = count != 2'(DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

>>> src/shf_back.sv
module shf_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  shf_pkg::cmd_t               cmd,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [shf_pkg::PAINT_W-1:0] pixel_value,
  output logic                        out_of_range
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = shf_pkg::RADIUS_W;
  localparam int SQW   = 2 * RW;
  localparam int PW    = 2 * SQW;
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam int DXW   = ((XW + FRAC_BITS) > RW ? (XW + FRAC_BITS) : RW) + 2;
  localparam int DYW   = ((YW + FRAC_BITS) > RW ? (YW + FRAC_BITS) : RW) + 2;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SQUARE = 8'b0000_0100,
    ST_LIMIT  = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_DRAIN  = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  shf_pkg::cmd_t cur;
  logic [AW-1:0] clr_addr;
  logic [XW-1:0] x_cnt;
  logic [YW-1:0] y_cnt;
  logic          x_last, y_last;
  logic          result_load;

  logic [SQW-1:0] rx2, ry2;
  logic [PW-1:0]  lim;

  logic [DXW-1:0] dx_u, adx_full;
  logic [DYW-1:0] dy_u, ady_full;

  logic           a_valid, b_valid, c_valid;
  logic [AW-1:0]  a_addr, b_addr, c_addr;
  logic           a_in, b_in, c_in;
  logic [RW-1:0]  a_adx, a_ady;
  logic [SQW-1:0] b_adx2, b_ady2;
  logic [PW-1:0]  c_tx, c_ty;
  logic [PW:0]    c_sum;

  logic [shf_pkg::PAINT_W-1:0] mem [DEPTH];
  logic [shf_pkg::PAINT_W-1:0] rd_data;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  logic [shf_pkg::PAINT_W-1:0] mem_wdata;

  assign cmd_ready   = state == ST_IDLE;
  assign clearing    = state == ST_CLEAR;
  assign x_last      = x_cnt == cur.x_hi[XW-1:0];
  assign y_last      = y_cnt == cur.y_hi[YW-1:0];
  assign result_load = (state == ST_RESULT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.skip) begin
            state_next = ST_RESULT;
          end else begin
            case (cmd.kind)
              shf_pkg::KIND_READ:    state_next = ST_READ;
              shf_pkg::KIND_ELLIPSE: state_next = ST_SQUARE;
              default:               state_next = ST_SCAN;
            endcase
          end
        end
      end
      ST_SQUARE: state_next = ST_LIMIT;
      ST_LIMIT:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (x_last && y_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!a_valid && !b_valid && !c_valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_READ: state_next = ST_RESULT;
      ST_RESULT: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= state == ST_SCAN;
      b_valid <= a_valid;
      c_valid <= b_valid;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan position and ellipse setup
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cur   <= cmd;
      x_cnt <= cmd.x_lo[XW-1:0];
      y_cnt <= cmd.y_lo[YW-1:0];
    end else if (state == ST_SCAN) begin
      if (x_last) begin
        x_cnt <= cur.x_lo[XW-1:0];
        y_cnt <= y_cnt + 1'b1;
      end else begin
        x_cnt <= x_cnt + 1'b1;
      end
    end
    if (state == ST_SQUARE) begin
      rx2 <= SQW'(cur.rx) * SQW'(cur.rx);
      ry2 <= SQW'(cur.ry) * SQW'(cur.ry);
    end
    if (state == ST_LIMIT) begin
      lim <= PW'(rx2) * PW'(ry2);
    end
  end

  // Distance from the pixel center to the ellipse center, in fraction units
  always_comb begin
    dx_u = (DXW'(x_cnt) << FRAC_BITS) + DXW'(HALF) - DXW'(cur.cx);
    dy_u = (DYW'(y_cnt) << FRAC_BITS) + DYW'(HALF) - DYW'(cur.cy);
    adx_full = dx_u[DXW-1] ? (~dx_u + 1'b1) : dx_u;
    ady_full = dy_u[DYW-1] ? (~dy_u + 1'b1) : dy_u;
  end

  // Pixel pipeline: distances, squares, cross products, then compare and write
  always_ff @(posedge clk) begin
    a_addr <= AW'(AW'(y_cnt) * AW'(MAX_WIDTH)) + AW'(x_cnt);
    a_adx  <= adx_full[RW-1:0];
    a_ady  <= ady_full[RW-1:0];
    a_in   <= (adx_full <= DXW'(cur.rx)) && (ady_full <= DYW'(cur.ry));
    b_addr <= a_addr;
    b_in   <= a_in;
    b_adx2 <= SQW'(a_adx) * SQW'(a_adx);
    b_ady2 <= SQW'(a_ady) * SQW'(a_ady);
    c_addr <= b_addr;
    c_in   <= b_in;
    c_tx   <= PW'(b_adx2) * PW'(ry2);
    c_ty   <= PW'(b_ady2) * PW'(rx2);
  end

  always_comb begin
    c_sum     = (PW + 1)'(c_tx) + (PW + 1)'(c_ty);
    mem_we    = clearing || (c_valid && ((cur.kind != shf_pkg::KIND_ELLIPSE)
                || (c_in && (c_sum <= (PW + 1)'(lim)))));
    mem_waddr = clearing ? clr_addr : c_addr;
    mem_wdata = clearing ? '0 : cur.paint;
    mem_raddr = AW'(AW'(cur.y_lo[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(cur.x_lo[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      pixel_value  <= (cur.kind == shf_pkg::KIND_READ && !cur.skip) ? rd_data : '0;
      out_of_range <= (cur.kind == shf_pkg::KIND_READ) && cur.skip;
    end
  end

endmodule

>>> sim/shape_fill_rasterizer_tb.sv
`timescale 1ns / 1ps

module shape_fill_rasterizer_tb;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int FRAC = 4;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int CHOKE_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int CTR_W = shf_pkg::CENTER_W;
  localparam int RAD_W = shf_pkg::RADIUS_W;
  localparam int DATA_W = shf_pkg::DIM_W;
  localparam logic [shf_pkg::INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [shf_pkg::INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    shf_pkg::kind_t                      kind;
    logic signed [10:0]                  x0;
    logic signed [10:0]                  y0;
    logic signed [10:0]                  x1;
    logic signed [10:0]                  y1;
    logic signed [shf_pkg::CENTER_W-1:0] cx;
    logic signed [shf_pkg::CENTER_W-1:0] cy;
    logic [shf_pkg::RADIUS_W-1:0]        rx;
    logic [shf_pkg::RADIUS_W-1:0]        ry;
    logic [shf_pkg::PAINT_W-1:0]         paint;
  } draw_cmd_t;

  typedef struct packed {
    logic [shf_pkg::PAINT_W-1:0] pixel;
    logic                        oor;
  } pixel_result_t;

  typedef struct packed {
    draw_cmd_t                   cmd;
    logic                        typed;
    logic [shf_pkg::PAINT_W-1:0] pix;
    logic                        oor;
  } stim_row_t;

  typedef struct packed {
    logic [shf_pkg::DIM_W-1:0] w;
    logic [shf_pkg::DIM_W-1:0] h;
    logic [7:0]                items;
    logic                      calm;
    logic                      spare_writes;
    logic                      choke;
    logic                      pause;
  } phase_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [shf_pkg::INDEX_W-1:0]         cfg_index = '0;
  logic [shf_pkg::DIM_W-1:0]           cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          kind = '0;
  logic signed [10:0]                  corner_x0 = '0;
  logic signed [10:0]                  corner_y0 = '0;
  logic signed [10:0]                  corner_x1 = '0;
  logic signed [10:0]                  corner_y1 = '0;
  logic signed [shf_pkg::CENTER_W-1:0] center_x = '0;
  logic signed [shf_pkg::CENTER_W-1:0] center_y = '0;
  logic [shf_pkg::RADIUS_W-1:0]        radius_x = '0;
  logic [shf_pkg::RADIUS_W-1:0]        radius_y = '0;
  logic [shf_pkg::PAINT_W-1:0]         paint = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [shf_pkg::PAINT_W-1:0]         pixel_value;
  logic                                out_of_range;

  logic [shf_pkg::PAINT_W-1:0] frame_model [0:MAX_W*MAX_H-1];
  logic [shf_pkg::DIM_W-1:0]   width_reg;
  logic [shf_pkg::DIM_W-1:0]   height_reg;
  pixel_result_t               pending_results [$];
  int                          errors = 0;
  int                          results_seen = 0;
  int                          cycle_count = 0;
  bit                          calm = 1'b0;
  bit                          choke_request = 1'b0;

  shape_fill_rasterizer #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .corner_x0   (corner_x0),
    .corner_y0   (corner_y0),
    .corner_x1   (corner_x1),
    .corner_y1   (corner_y1),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .paint       (paint),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .out_of_range(out_of_range)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  function automatic int eff_dim(input logic [shf_pkg::DIM_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Update the frame model for one command and work out its result.
  task automatic predict_command(input draw_cmd_t c, output pixel_result_t r);
    int w, h, x, y, x0, y0, x1, y1;
    longint cx, cy, rx, ry, adx, ady, lim, half;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    half = longint'(1) << (FRAC - 1);
    r = '0;
    case (c.kind)
      shf_pkg::KIND_FILL: begin
        for (y = 0; y < h; y++)
          for (x = 0; x < w; x++) frame_model[y*MAX_W + x] = c.paint;
      end
      shf_pkg::KIND_RECT: begin
        x0 = int'(c.x0);
        y0 = int'(c.y0);
        x1 = int'(c.x1);
        y1 = int'(c.y1);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > w - 1) x1 = w - 1;
        if (y1 > h - 1) y1 = h - 1;
        for (y = y0; y <= y1; y++)
          for (x = x0; x <= x1; x++) frame_model[y*MAX_W + x] = c.paint;
      end
      shf_pkg::KIND_ELLIPSE: begin
        cx = longint'(c.cx);
        cy = longint'(c.cy);
        rx = longint'(c.rx);
        ry = longint'(c.ry);
        // drop ellipses thinner than half a pixel
        if (rx >= half && ry >= half) begin
          lim = rx * rx * ry * ry;
          for (y = 0; y < h; y++) begin
            ady = (longint'(y) << FRAC) + half - cy;
            if (ady < 0) ady = -ady;
            if (ady <= ry) begin
              for (x = 0; x < w; x++) begin
                adx = (longint'(x) << FRAC) + half - cx;
                if (adx < 0) adx = -adx;
                if (adx <= rx && adx*adx*ry*ry + ady*ady*rx*rx <= lim)
                  frame_model[y*MAX_W + x] = c.paint;
              end
            end
          end
        end
      end
      default: begin
        x0 = int'(c.x0);
        y0 = int'(c.y0);
        if (x0 < 0 || y0 < 0 || x0 >= w || y0 >= h) r.oor = 1'b1;
        else r.pixel = frame_model[y0*MAX_W + x0];
      end
    endcase
  endtask

  function automatic stim_row_t read_row(input int x, input int y, input logic typed,
                                         input logic [shf_pkg::PAINT_W-1:0] pix,
                                         input logic oor);
    stim_row_t s;
    s = '0;
    s.cmd.kind = shf_pkg::KIND_READ;
    s.cmd.x0 = 11'(x);
    s.cmd.y0 = 11'(y);
    s.typed = typed;
    s.pix = pix;
    s.oor = oor;
    return s;
  endfunction

  // Drawing commands always return zeros, so their rows carry a typed result.
  function automatic stim_row_t draw_row(input shf_pkg::kind_t k, input int x0, input int y0,
                                         input int x1, input int y1, input int cx,
                                         input int cy, input int rx, input int ry,
                                         input logic [shf_pkg::PAINT_W-1:0] color);
    stim_row_t s;
    s = '0;
    s.cmd.kind = k;
    s.cmd.x0 = 11'(x0);
    s.cmd.y0 = 11'(y0);
    s.cmd.x1 = 11'(x1);
    s.cmd.y1 = 11'(y1);
    s.cmd.cx = CTR_W'(cx);
    s.cmd.cy = CTR_W'(cy);
    s.cmd.rx = RAD_W'(rx);
    s.cmd.ry = RAD_W'(ry);
    s.cmd.paint = color;
    s.typed = 1'b1;
    return s;
  endfunction

  function automatic draw_cmd_t random_cmd(input int w, input int h);
    draw_cmd_t c;
    int pick, lo;
    c.x0 = 11'($urandom);
    c.y0 = 11'($urandom);
    c.x1 = 11'($urandom);
    c.y1 = 11'($urandom);
    c.cx = CTR_W'($urandom);
    c.cy = CTR_W'($urandom);
    c.rx = RAD_W'($urandom);
    c.ry = RAD_W'($urandom);
    c.paint = $urandom;
    pick = int'($urandom_range(0, 99));
    if (pick < 15) begin
      c.kind = shf_pkg::KIND_FILL;
    end else if (pick < 40) begin
      c.kind = shf_pkg::KIND_RECT;
      if ($urandom_range(0, 9) != 0) begin
        lo = int'($urandom_range(0, w + 6)) - 4;
        c.x0 = 11'(lo);
        c.x1 = 11'(lo + int'($urandom_range(0, w)) - 2);
        lo = int'($urandom_range(0, h + 6)) - 4;
        c.y0 = 11'(lo);
        c.y1 = 11'(lo + int'($urandom_range(0, h)) - 2);
      end
    end else if (pick < 60) begin
      c.kind = shf_pkg::KIND_ELLIPSE;
      if ($urandom_range(0, 9) != 0) begin
        c.cx = CTR_W'(int'($urandom_range(0, (w + 8) * 16)) - 64);
        c.cy = CTR_W'(int'($urandom_range(0, (h + 8) * 16)) - 64);
        c.rx = RAD_W'($urandom_range(0, 640));
        c.ry = RAD_W'($urandom_range(0, 640));
        // sit near the half-pixel threshold now and then
        if ($urandom_range(0, 5) == 0) c.rx = RAD_W'($urandom_range(0, 12));
        if ($urandom_range(0, 5) == 0) c.ry = RAD_W'($urandom_range(0, 12));
      end
    end else begin
      c.kind = shf_pkg::KIND_READ;
      if ($urandom_range(0, 9) != 0) begin
        c.x0 = 11'(int'($urandom_range(0, w + 1)) - 1);
        c.y0 = 11'(int'($urandom_range(0, h + 1)) - 1);
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [shf_pkg::PAINT_W-1:0] got,
                                 input logic [shf_pkg::PAINT_W-1:0] want);
    $display("mismatch: %s got %h want %h at result %0d", what, got, want, results_seen);
    errors++;
  endtask

  // Offer one command, hold it until the transfer, then record what it returns.
  task automatic issue(input draw_cmd_t c, input logic typed,
                       input logic [shf_pkg::PAINT_W-1:0] pix, input logic oor);
    int gap;
    pixel_result_t r;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= c.kind;
    corner_x0 <= c.x0;
    corner_y0 <= c.y0;
    corner_x1 <= c.x1;
    corner_y1 <= c.y1;
    center_x  <= c.cx;
    center_y  <= c.cy;
    radius_x  <= c.rx;
    radius_y  <= c.ry;
    paint     <= c.paint;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(c, r);
    if (typed) begin
      r.pixel = pix;
      r.oor = oor;
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_canvas(input logic [shf_pkg::DIM_W-1:0] w,
                                input logic [shf_pkg::DIM_W-1:0] h,
                                input logic spare_writes);
    cfg_we    <= 1'b1;
    cfg_index <= shf_pkg::REG_CANVAS_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= shf_pkg::REG_CANVAS_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h;
    if (spare_writes) begin
      // unused indexes must leave both registers alone
      cfg_index <= REG_SPARE_A;
      cfg_data  <= DATA_W'($urandom);
      @(posedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_data  <= DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", pixel_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (pixel_value !== want.pixel)
          report_mismatch("pixel_value", pixel_value, want.pixel);
        if (out_of_range !== want.oor)
          report_mismatch("out_of_range", {31'd0, out_of_range}, {31'd0, want.oor});
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (choke_request) begin
        // hold off long enough for the command queue to back up
        choke_request = 1'b0;
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed [$];
    phase_t    phases [$];
    phase_t    ph;
    stim_row_t rd;
    int        i, p;

    for (i = 0; i < MAX_W*MAX_H; i++) frame_model[i] = '0;
    width_reg = shf_pkg::CANVAS_RESET;
    height_reg = shf_pkg::CANVAS_RESET;

    directed.push_back(read_row(0, 0, 1'b1, 32'h0, 1'b0));
    directed.push_back(read_row(63, 63, 1'b1, 32'h0, 1'b0));
    directed.push_back(read_row(64, 0, 1'b1, 32'h0, 1'b1));
    directed.push_back(read_row(0, 64, 1'b1, 32'h0, 1'b1));
    directed.push_back(read_row(-1, 5, 1'b1, 32'h0, 1'b1));
    directed.push_back(read_row(-1024, 1023, 1'b1, 32'h0, 1'b1));
    directed.push_back(read_row(1023, -1024, 1'b1, 32'h0, 1'b1));
    directed.push_back(draw_row(shf_pkg::KIND_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(read_row(63, 63, 1'b1, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(read_row(0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(draw_row(shf_pkg::KIND_RECT, -1024, -1024, 1023, 1023, 0, 0, 0, 0,
                                32'h0));
    directed.push_back(read_row(31, 17, 1'b1, 32'h0, 1'b0));
    directed.push_back(draw_row(shf_pkg::KIND_RECT, 5, 5, 4, 9, 0, 0, 0, 0, 32'hA5A5_A5A5));
    directed.push_back(draw_row(shf_pkg::KIND_RECT, 3, 9, 9, 3, 0, 0, 0, 0, 32'h5A5A_5A5A));
    directed.push_back(read_row(5, 5, 1'b1, 32'h0, 1'b0));
    directed.push_back(draw_row(shf_pkg::KIND_RECT, 2, 3, 5, 7, 0, 0, 0, 0, 32'h1234_5678));
    directed.push_back(read_row(2, 3, 1'b1, 32'h1234_5678, 1'b0));
    directed.push_back(read_row(6, 7, 1'b1, 32'h0, 1'b0));
    directed.push_back(draw_row(shf_pkg::KIND_RECT, 70, 70, 1000, 1000, 0, 0, 0, 0,
                                32'hDEAD_BEEF));
    directed.push_back(draw_row(shf_pkg::KIND_ELLIPSE, 0, 0, 0, 0, 168, 168, 7, 800,
                                32'h1111_1111));
    directed.push_back(draw_row(shf_pkg::KIND_ELLIPSE, 0, 0, 0, 0, 168, 168, 8, 8,
                                32'h8765_4321));
    directed.push_back(read_row(10, 10, 1'b1, 32'h8765_4321, 1'b0));
    directed.push_back(draw_row(shf_pkg::KIND_ELLIPSE, 0, 0, 0, 0, -4096, 8191, 8191, 8191,
                                32'h00FF_00FF));
    directed.push_back(draw_row(shf_pkg::KIND_ELLIPSE, 0, 0, 0, 0, 512, 520, 8191, 8,
                                32'hC0FF_EE00));
    directed.push_back(read_row(11, 10, 1'b0, 32'h0, 1'b0));

    //                        w       h       items calm spare choke pause
    phases.push_back('{7'd64,  7'd64,  8'd10, 1'b0, 1'b0, 1'b0, 1'b0});
    phases.push_back('{7'd1,   7'd1,   8'd10, 1'b1, 1'b0, 1'b0, 1'b0});
    phases.push_back('{7'd0,   7'd0,   8'd10, 1'b0, 1'b1, 1'b0, 1'b0});
    phases.push_back('{7'd127, 7'd100, 8'd10, 1'b0, 1'b0, 1'b0, 1'b0});
    phases.push_back('{7'd17,  7'd5,   8'd15, 1'b0, 1'b1, 1'b0, 1'b1});
    phases.push_back('{7'd64,  7'd1,   8'd10, 1'b1, 1'b0, 1'b0, 1'b0});
    phases.push_back('{7'd1,   7'd64,  8'd10, 1'b0, 1'b0, 1'b0, 1'b0});
    phases.push_back('{7'd40,  7'd33,  8'd17, 1'b0, 1'b1, 1'b1, 1'b0});
    phases.push_back('{7'd64,  7'd64,  8'd15, 1'b0, 1'b0, 1'b0, 1'b1});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed.size(); i++)
      issue(directed[i].cmd, directed[i].typed, directed[i].pix, directed[i].oor);

    for (p = 0; p < phases.size(); p++) begin
      ph = phases[p];
      if (p > 0) begin
        wait_idle();
        program_canvas(ph.w, ph.h, ph.spare_writes);
      end
      if (ph.choke) begin
        // back-to-back reads while the sink holds off
        calm = 1'b1;
        choke_request = 1'b1;
        for (i = 0; i < 8; i++) begin
          rd = read_row(int'($urandom_range(0, eff_dim(width_reg, MAX_W) - 1)),
                        int'($urandom_range(0, eff_dim(height_reg, MAX_H) - 1)),
                        1'b0, 32'h0, 1'b0);
          issue(rd.cmd, 1'b0, 32'h0, 1'b0);
        end
      end
      calm = ph.calm;
      for (i = 0; i < ph.items; i++) begin
        if (ph.pause && i == ph.items / 2) wait_idle();
        issue(random_cmd(eff_dim(width_reg, MAX_W), eff_dim(height_reg, MAX_H)),
              1'b0, 32'h0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
